// ----- rtl/g2j_pkg.sv -----
// g2j_pkg: constants, types and month tables for the Gregorian to Jalali converter.
// Used by gregorian_to_jalali; depends on nothing.

package g2j_pkg;

   typedef logic [17:0] day_count_type;
   typedef logic [10:0] jal_year_type;

   localparam logic [11:0] YearLow      = 12'd2000;
   localparam logic [11:0] YearHigh     = 12'd2100;
   localparam logic [11:0] YearFallback = 12'd2012;
   localparam logic [11:0] EpochYear    = 12'd1600;
   localparam logic [3:0]  MonthMax     = 4'd12;
   localparam logic [5:0]  DayMax       = 6'd31;

   // century corrections collapse to -3 over 2000..2100; plus day-1 and the 79-day shift
   localparam day_count_type DayOffset  = 18'd83;
   // twelve whole 33-year cycles
   localparam day_count_type BaseDays   = 18'd144636;
   localparam logic [8:0]    PlainDays  = 9'd365;
   localparam logic [8:0]    LeapDays   = 9'd366;
   localparam logic [13:0]   CycleDays  = 14'd12053;
   localparam logic [10:0]   GroupDays  = 11'd1461;
   localparam logic [8:0]    CentLeapGy = 9'd500;
   localparam jal_year_type  JalBase    = 11'd1375;
   localparam int            CycleYears = 33;

   function automatic logic [8:0] greg_month_start(input logic [3:0] m);
      logic [8:0] s;
      case (m)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // day of year at which Jalali month jm (0-based) begins
   function automatic logic [8:0] jal_month_start(input logic [3:0] jm);
      logic [8:0] s;
      case (jm)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd62;
         4'd3:    s = 9'd93;
         4'd4:    s = 9'd124;
         4'd5:    s = 9'd155;
         4'd6:    s = 9'd186;
         4'd7:    s = 9'd216;
         4'd8:    s = 9'd246;
         4'd9:    s = 9'd276;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd336;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/gregorian_to_jalali.sv -----
// gregorian_to_jalali: five-stage pipelined Gregorian to Jalali date converter.
// Depends on g2j_pkg.

// One date enters per cycle while the pipeline is not stalled, and its Jalali
// date leaves from the last stage. Stages: day count since 1600, split
// into 33-year cycles, 4-year groups, single years, then month and day. Each
// stage holds its word under rsp_tready backpressure; bubbles are squeezed out.
// Out-of-range fields are replaced (year by 2012, month and day by 1) before
// conversion; impossible dates such as 30 February roll into the next month.

module gregorian_to_jalali (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // greg_year[11:0], greg_month[15:12], greg_day[21:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // jal_year[10:0], jal_month[14:11], jal_day[19:15]
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || rsp_tready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   // stage 1: sanitize and count days
   logic [11:0] greg_year;
   logic [3:0]  greg_month;
   logic [5:0]  greg_day;
   logic [11:0] year_v;
   logic [3:0]  month_v;
   logic [5:0]  day_v;
   logic [8:0]  gy;
   logic        leap;
   g2j_pkg::day_count_type days1_in, days1_ff;

   assign greg_year  = req_tdata[11:0];
   assign greg_month = req_tdata[15:12];
   assign greg_day   = req_tdata[21:16];

   always_comb begin
      year_v  = (greg_year < g2j_pkg::YearLow || greg_year > g2j_pkg::YearHigh) ?
                g2j_pkg::YearFallback : greg_year;
      month_v = (greg_month == 4'd0 || greg_month > g2j_pkg::MonthMax) ? 4'd1 : greg_month;
      day_v   = (greg_day == 6'd0 || greg_day > g2j_pkg::DayMax) ? 6'd1 : greg_day;
      gy      = 9'(year_v - g2j_pkg::EpochYear);
      leap    = (gy[1:0] == 2'd0) && (gy != g2j_pkg::CentLeapGy);
      days1_in = 18'(gy) * 18'(g2j_pkg::PlainDays)
               + 18'((10'(gy) + 10'd3) >> 2)
               + 18'(g2j_pkg::greg_month_start(month_v))
               + 18'(leap && (month_v > 4'd2))
               + 18'(day_v)
               - g2j_pkg::DayOffset;
   end

   always_ff @(posedge clock) begin
      if (adv1) days1_ff <= days1_in;
   end

   // stage 2: 33-year cycles
   logic [15:0] r2_full;
   logic [1:0]  cyc2_in, cyc2_ff;
   logic [13:0] rem2_in, rem2_ff;

   always_comb begin
      r2_full = 16'(days1_ff - g2j_pkg::BaseDays);
      cyc2_in = 2'(r2_full >= 16'(g2j_pkg::CycleDays))
              + 2'(r2_full >= 16'(2 * g2j_pkg::CycleDays))
              + 2'(r2_full >= 16'(3 * g2j_pkg::CycleDays));
      rem2_in = 14'(r2_full - 16'(cyc2_in) * 16'(g2j_pkg::CycleDays));
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         cyc2_ff <= cyc2_in;
         rem2_ff <= rem2_in;
      end
   end

   // stage 3: 4-year groups
   logic [3:0]  grp3;
   logic [10:0] rem3_in, rem3_ff;
   g2j_pkg::jal_year_type jy3_in, jy3_ff;

   always_comb begin
      grp3 = 4'd0;
      for (int k = 1; k <= 8; k++) begin
         grp3 = grp3 + 4'(rem2_ff >= 14'(k * g2j_pkg::GroupDays));
      end
      rem3_in = 11'(rem2_ff - 14'(grp3) * 14'(g2j_pkg::GroupDays));
      jy3_in  = g2j_pkg::JalBase + 11'(cyc2_ff) * 11'(g2j_pkg::CycleYears)
              + {5'd0, grp3, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         rem3_ff <= rem3_in;
         jy3_ff  <= jy3_in;
      end
   end

   // stage 4: year within group; first year is the leap one
   logic [10:0] t4;
   logic [1:0]  yr4;
   logic [8:0]  rem4_in, rem4_ff;
   g2j_pkg::jal_year_type jy4_in, jy4_ff;

   always_comb begin
      t4  = rem3_ff - 11'd1;
      yr4 = 2'(t4 >= 11'(g2j_pkg::PlainDays))
          + 2'(t4 >= 11'(2 * g2j_pkg::PlainDays))
          + 2'(t4 >= 11'(3 * g2j_pkg::PlainDays));
      if (rem3_ff >= 11'(g2j_pkg::LeapDays)) begin
         rem4_in = 9'(t4 - 11'(yr4) * 11'(g2j_pkg::PlainDays));
         jy4_in  = jy3_ff + 11'(yr4);
      end else begin
         rem4_in = 9'(rem3_ff);
         jy4_in  = jy3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         rem4_ff <= rem4_in;
         jy4_ff  <= jy4_in;
      end
   end

   // stage 5: month and day
   logic [3:0] jm5;
   logic [3:0] mon5_in, mon5_ff;
   logic [4:0] day5_in, day5_ff;
   g2j_pkg::jal_year_type year5_ff;

   always_comb begin
      jm5 = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         jm5 = jm5 + 4'(rem4_ff >= g2j_pkg::jal_month_start(4'(k)));
      end
      mon5_in = jm5 + 4'd1;
      day5_in = 5'(rem4_ff - g2j_pkg::jal_month_start(jm5) + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         mon5_ff  <= mon5_in;
         day5_ff  <= day5_in;
         year5_ff <= jy4_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {4'd0, day5_ff, mon5_ff, year5_ff};

`ifndef ASSERT_OFF
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mon5_ff != 4'd0 && mon5_ff <= 4'd12))
      else $error("jalali month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (day5_ff != 5'd0 && (mon5_ff <= 4'd6 || day5_ff <= 5'd30)))
      else $error("jalali day out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (year5_ff >= 11'd1378 && year5_ff <= 11'd1479))
      else $error("jalali year out of range");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted word missing from first stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv3 |=> v3_ff && $stable(rem3_ff) && $stable(jy3_ff))
      else $error("stalled stage lost its word");
`endif

endmodule
